// ===== design/wpal_pkg.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// wpal_pkg
// shared types and constants of the windowed pulse average logger
// ------------------------------------------------------------------------
package wpal_pkg;

    localparam int MAX_AVG     = 64;
    localparam int MAX_RECORDS = 1024;
    localparam int MIN_RECORDS = 1;

    localparam int AVG_W    = 7;
    localparam int ACTIVE_W = 11;
    localparam int CFG_W    = 11;
    localparam int PULSE_W  = 16;
    localparam int SUM_W    = 22;
    localparam int DIR_W    = 8;
    localparam int IDX_W    = 10;
    localparam int REC_W    = 11;
    localparam int STEP_W   = $clog2(SUM_W);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // register indexes
    localparam logic REG_WINDOW_LEN     = 1'b0;
    localparam logic REG_ACTIVE_SAMPLES = 1'b1;

    // input kinds
    localparam logic KIND_PIN  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // one closed window waiting for its division
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [AVG_W-1:0] count;
        logic [DIR_W-1:0] direction;
        logic [IDX_W-1:0] index;
        logic             done;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_HOLD
    } back_state_t;

endpackage

// ===== design/wpal_front.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// wpal_front
// accepts items, counts pulses, sums windows and issues division jobs
// ------------------------------------------------------------------------
module wpal_front
    import wpal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                accept,
    input  logic                kind,
    input  logic                pin_level,
    input  logic [DIR_W-1:0]    vane_bits,
    output logic                job_push,
    output job_t                job
);

    logic [AVG_W-1:0]    window_len_reg,     window_len_next;
    logic [ACTIVE_W-1:0] active_samples_reg, active_samples_next;
    logic [PULSE_W-1:0]  pulse_count_reg,    pulse_count_next;
    logic [SUM_W-1:0]    speed_sum_reg,      speed_sum_next;
    logic [AVG_W-1:0]    window_count_reg,   window_count_next;
    logic [REC_W-1:0]    record_count_reg,   record_count_next;

    logic [SUM_W-1:0] sum_add;
    logic [AVG_W-1:0] win_add;
    logic [REC_W-1:0] rec_add;
    logic             tick_live;
    logic             window_close;

    // clamped configuration writes
    always_comb
    begin
        window_len_next     = window_len_reg;
        active_samples_next = active_samples_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_LEN:
                begin
                    if (cfg_data[AVG_W-1:0] == '0)
                        window_len_next = AVG_W'(1);
                    else if (cfg_data[AVG_W-1:0] > AVG_W'(MAX_AVG))
                        window_len_next = AVG_W'(MAX_AVG);
                    else
                        window_len_next = cfg_data[AVG_W-1:0];
                end
                REG_ACTIVE_SAMPLES:
                begin
                    if (cfg_data[ACTIVE_W-1:0] < ACTIVE_W'(MIN_RECORDS))
                        active_samples_next = ACTIVE_W'(MIN_RECORDS);
                    else if (cfg_data[ACTIVE_W-1:0] > ACTIVE_W'(MAX_RECORDS))
                        active_samples_next = ACTIVE_W'(MAX_RECORDS);
                    else
                        active_samples_next = cfg_data[ACTIVE_W-1:0];
                end
            endcase
        end
    end

    // item classification and window bookkeeping
    always_comb
    begin
        sum_add      = speed_sum_reg + SUM_W'(pulse_count_reg);
        win_add      = window_count_reg + AVG_W'(1);
        rec_add      = record_count_reg + REC_W'(1);
        tick_live    = accept && (kind == KIND_TICK)
                       && (record_count_reg < REC_W'(active_samples_reg));
        window_close = (win_add >= window_len_reg) && (win_add != '0);

        pulse_count_next  = pulse_count_reg;
        speed_sum_next    = speed_sum_reg;
        window_count_next = window_count_reg;
        record_count_next = record_count_reg;
        job_push          = 1'b0;

        job.sum       = sum_add;
        job.count     = win_add;
        job.direction = vane_bits;
        job.index     = record_count_reg[IDX_W-1:0];
        job.done      = (rec_add >= REC_W'(active_samples_reg));

        if (accept && (kind == KIND_PIN) && pin_level)
            pulse_count_next = pulse_count_reg + PULSE_W'(1);

        if (tick_live)
        begin
            pulse_count_next = '0;
            if (window_close)
            begin
                job_push          = 1'b1;
                speed_sum_next    = '0;
                window_count_next = '0;
                record_count_next = rec_add;
            end
            else
            begin
                speed_sum_next    = sum_add;
                window_count_next = win_add;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg     <= AVG_W'(1);
            active_samples_reg <= ACTIVE_W'(MAX_RECORDS);
            pulse_count_reg    <= '0;
            speed_sum_reg      <= '0;
            window_count_reg   <= '0;
            record_count_reg   <= '0;
        end
        else
        begin
            window_len_reg     <= window_len_next;
            active_samples_reg <= active_samples_next;
            pulse_count_reg    <= pulse_count_next;
            speed_sum_reg      <= speed_sum_next;
            window_count_reg   <= window_count_next;
            record_count_reg   <= record_count_next;
        end
    end

endmodule

// ===== design/wpal_job_fifo.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// wpal_job_fifo
// short queue of division jobs between the front and the back
// ------------------------------------------------------------------------
module wpal_job_fifo
    import wpal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  job_t         wr_job,
    input  logic         rd_en,
    output job_t         rd_job,
    output fifo_status_t status
);

    job_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] level_reg,  level_next;
    logic                  do_wr;
    logic                  do_rd;

    // pointer and fill level update
    always_comb
    begin
        status.empty = (level_reg == '0);
        status.full  = (level_reg == FIFO_CNT_W'(FIFO_DEPTH));
        do_wr        = wr_en && !status.full;
        do_rd        = rd_en && !status.empty;
        rd_job       = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + FIFO_PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + FIFO_PTR_W'(1);

        unique case ({do_wr, do_rd})
            2'b10:   level_next = level_reg + FIFO_CNT_W'(1);
            2'b01:   level_next = level_reg - FIFO_CNT_W'(1);
            default: level_next = level_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== design/wpal_back.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// wpal_back
// serial restoring divider and result register
// ------------------------------------------------------------------------
module wpal_back
    import wpal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  job_t                job,
    output logic                job_pop,
    input  logic                pop,
    output logic                empty,
    output logic [PULSE_W-1:0]  mean_speed,
    output logic [DIR_W-1:0]    direction,
    output logic [IDX_W-1:0]    record_index,
    output logic                capture_done
);

    back_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic                out_valid_reg, out_valid_next;

    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [AVG_W-1:0]    rem_reg, rem_next;
    logic [AVG_W-1:0]    divisor_reg, divisor_next;
    logic [DIR_W-1:0]    dir_reg, dir_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                done_reg, done_next;

    logic [PULSE_W-1:0]  mean_reg, mean_next;
    logic [DIR_W-1:0]    out_dir_reg, out_dir_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic                out_done_reg, out_done_next;

    logic [AVG_W:0]      trial;
    logic [AVG_W:0]      diff;
    logic [SUM_W-1:0]    quo_step;
    logic [AVG_W-1:0]    rem_step;
    logic                slot_free;
    logic                load_out;
    logic [PULSE_W-1:0]  load_mean;

    // one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_step = diff[AVG_W-1:0];
            quo_step = {quo_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_step = trial[AVG_W-1:0];
            quo_step = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    // sequencer and result register control
    always_comb
    begin
        slot_free    = !out_valid_reg || pop;
        state_next   = state_reg;
        step_next    = step_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        dir_next     = dir_reg;
        idx_next     = idx_reg;
        done_next    = done_reg;
        job_pop      = 1'b0;
        load_out     = 1'b0;
        load_mean    = quo_reg[PULSE_W-1:0];

        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop      = 1'b1;
                    quo_next     = job.sum;
                    rem_next     = '0;
                    divisor_next = job.count;
                    dir_next     = job.direction;
                    idx_next     = job.index;
                    done_next    = job.done;
                    step_next    = '0;
                    state_next   = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    if (slot_free)
                    begin
                        load_out   = 1'b1;
                        load_mean  = quo_step[PULSE_W-1:0];
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_HOLD;
                    end
                end
            end
            BK_HOLD:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        mean_next     = load_out ? load_mean : mean_reg;
        out_dir_next  = load_out ? dir_reg   : out_dir_reg;
        out_idx_next  = load_out ? idx_reg   : out_idx_reg;
        out_done_next = load_out ? done_reg  : out_done_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        dir_reg      <= dir_next;
        idx_reg      <= idx_next;
        done_reg     <= done_next;
        mean_reg     <= mean_next;
        out_dir_reg  <= out_dir_next;
        out_idx_reg  <= out_idx_next;
        out_done_reg <= out_done_next;
    end

    assign empty        = !out_valid_reg;
    assign mean_speed   = mean_reg;
    assign direction    = out_dir_reg;
    assign record_index = out_idx_reg;
    assign capture_done = out_done_reg;

endmodule

// ===== design/windowed_pulse_average_logger_core.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// windowed_pulse_average_logger_core
// anemometer pulse counter with boxcar averaging of wind speed records
// ------------------------------------------------------------------------
// Usage:
//   Input items (kind, pin_level, vane_bits) are pushed with push while
//   full is low. A pin change item with pin_level high bumps the pulse
//   count; a sample tick folds the count into the current window and,
//   once the window length in ticks is reached, closes it as one record.
//   Records leave through empty/pop: the oldest record is on the result
//   ports while empty is low and goes away on pop.
//   The front takes one item per cycle while full is low. A closed window
//   is queued (two deep) for the back, where a serial restoring divider
//   makes one quotient bit per cycle. A record goes from the queue through
//   the divider into the result register, which drives the result ports.
//   full rises only while the job queue holds two records; when pop
//   stalls, one record waits in the result register, one in the divider
//   and two in the queue before full blocks further items.
//   Reset sets the window length to 1, active_samples to 1024, clears all
//   counters and empties the queue and the result register. Configuration
//   writes (cfg_we, cfg_index, cfg_data) take effect at once and are clamped.
// ------------------------------------------------------------------------
module windowed_pulse_average_logger_core
    import wpal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                push,
    output logic                full,
    input  logic                kind,
    input  logic                pin_level,
    input  logic [DIR_W-1:0]    vane_bits,
    output logic                empty,
    input  logic                pop,
    output logic [PULSE_W-1:0]  mean_speed,
    output logic [DIR_W-1:0]    direction,
    output logic [IDX_W-1:0]    record_index,
    output logic                capture_done
);

    logic         accept;
    logic         job_push;
    logic         job_pop;
    job_t         front_job;
    job_t         queued_job;
    fifo_status_t fifo_status;

    assign full   = fifo_status.full;
    assign accept = push && !fifo_status.full;

    // front: item classification and window sums
    wpal_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .kind      (kind),
        .pin_level (pin_level),
        .vane_bits (vane_bits),
        .job_push  (job_push),
        .job       (front_job)
    );

    // queue of closed windows
    wpal_job_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (front_job),
        .rd_en  (job_pop),
        .rd_job (queued_job),
        .status (fifo_status)
    );

    // back: division and result register
    wpal_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!fifo_status.empty),
        .job          (queued_job),
        .job_pop      (job_pop),
        .pop          (pop),
        .empty        (empty),
        .mean_speed   (mean_speed),
        .direction    (direction),
        .record_index (record_index),
        .capture_done (capture_done)
    );

    // a job is only issued into a queue with room
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !fifo_status.full)
        else $error("job issued into a full queue");

    // the back only picks up a job that is queued
    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !fifo_status.empty)
        else $error("job taken from an empty queue");

    // a closed window never holds zero ticks
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (front_job.count != '0))
        else $error("record with an empty window");

    // a waiting record leaves only on pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !$past(empty) && !$past(pop)) |-> 1'b0)
        else $error("record vanished without pop");

endmodule

// ===== bench/windowed_pulse_average_logger_core_tb.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// windowed_pulse_average_logger_core_tb
// self-checking bench for the anemometer pulse averaging logger
// ------------------------------------------------------------------------
// A driver pushes pin change and sample tick items from a queue, and a
// monitor pops records. Both sides idle at random. Every accepted item
// goes through a bench-side model of the pulse counter, window sum and
// record counter. Each record that comes out is checked field by field
// against the oldest predicted one. The stimulus starts with directed
// items: clamped register writes, a window cut short and a capture that
// stops and resumes. Random phases with varied settings follow, and a
// final run closes the capture a few records later.
// ------------------------------------------------------------------------
module windowed_pulse_average_logger_core_tb;
    import wpal_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int FINAL_RECORDS = 8;

    typedef struct packed {
        logic             kind;
        logic             pin_level;
        logic [DIR_W-1:0] vane_bits;
    } wind_event_t;

    typedef struct packed {
        logic [PULSE_W-1:0] mean_speed;
        logic [DIR_W-1:0]   direction;
        logic [IDX_W-1:0]   record_index;
        logic               capture_done;
    } wind_record_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = 1'b0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               push      = 1'b0;
    logic               full;
    logic               kind      = 1'b0;
    logic               pin_level = 1'b0;
    logic [DIR_W-1:0]   vane_bits = '0;
    logic               empty;
    logic               pop       = 1'b0;
    logic [PULSE_W-1:0] mean_speed;
    logic [DIR_W-1:0]   direction;
    logic [IDX_W-1:0]   record_index;
    logic               capture_done;

    // model of the block state and its registers
    logic [AVG_W-1:0]    window_len     = AVG_W'(1);
    logic [ACTIVE_W-1:0] active_samples = ACTIVE_W'(MAX_RECORDS);
    logic [PULSE_W-1:0]  pulse_count    = '0;
    logic [SUM_W-1:0]    speed_sum      = '0;
    logic [AVG_W-1:0]    window_count   = '0;
    logic [DIR_W-1:0]    last_vane      = '0;
    logic [REC_W-1:0]    record_count   = '0;

    wind_event_t  events_to_send[$];
    wind_record_t records_owed[$];
    wind_event_t  next_event;
    wind_record_t owed;

    bit          holding      = 1'b0;
    bit          item_taken   = 1'b0;
    bit          record_taken = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned pop_stall    = 0;
    int unsigned cycle_count  = 0;
    int unsigned mismatch_count = 0;

    windowed_pulse_average_logger_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .pin_level    (pin_level),
        .vane_bits    (vane_bits),
        .empty        (empty),
        .pop          (pop),
        .mean_speed   (mean_speed),
        .direction    (direction),
        .record_index (record_index),
        .capture_done (capture_done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // clamped register write as the block sees it
    function automatic void write_model_register(input logic idx,
                                                 input logic [CFG_W-1:0] data);
        logic [AVG_W-1:0]    avg_raw;
        logic [ACTIVE_W-1:0] active_raw;
        avg_raw    = data[AVG_W-1:0];
        active_raw = data[ACTIVE_W-1:0];
        if (idx == REG_WINDOW_LEN)
        begin
            if (avg_raw < 1)
                window_len = AVG_W'(1);
            else if (avg_raw > MAX_AVG)
                window_len = AVG_W'(MAX_AVG);
            else
                window_len = avg_raw;
        end
        else
        begin
            if (active_raw < MIN_RECORDS)
                active_samples = ACTIVE_W'(MIN_RECORDS);
            else if (active_raw > MAX_RECORDS)
                active_samples = ACTIVE_W'(MAX_RECORDS);
            else
                active_samples = active_raw;
        end
    endfunction

    // fold one item into the window and queue the record it closes
    function automatic void log_wind_event(input wind_event_t ev);
        wind_record_t rec;
        if (ev.kind == KIND_PIN)
        begin
            if (ev.pin_level)
                pulse_count = pulse_count + PULSE_W'(1);
        end
        else if (record_count < active_samples)
        begin
            speed_sum    = speed_sum + SUM_W'(pulse_count);
            pulse_count  = '0;
            last_vane    = ev.vane_bits;
            window_count = window_count + AVG_W'(1);
            if (window_count != 0 && window_count >= window_len)
            begin
                rec.mean_speed   = PULSE_W'(speed_sum / SUM_W'(window_count));
                rec.direction    = last_vane;
                rec.record_index = record_count[IDX_W-1:0];
                record_count     = record_count + REC_W'(1);
                rec.capture_done = (record_count >= active_samples);
                speed_sum        = '0;
                window_count     = '0;
                records_owed.push_back(rec);
            end
        end
    endfunction

    // sample at the rising edge: check records, track writes and items
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("windowed_pulse_average_logger_core_tb NOT OK");
            $finish;
        end
        else if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (records_owed.size() == 0)
                begin
                    $error("unexpected record: mean_speed %0d record_index %0d",
                           mean_speed, record_index);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    owed = records_owed.pop_front();
                    if (mean_speed !== owed.mean_speed)
                    begin
                        $error("mean_speed: expected %0d, got %0d",
                               owed.mean_speed, mean_speed);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (direction !== owed.direction)
                    begin
                        $error("direction: expected %0h, got %0h",
                               owed.direction, direction);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (record_index !== owed.record_index)
                    begin
                        $error("record_index: expected %0d, got %0d",
                               owed.record_index, record_index);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (capture_done !== owed.capture_done)
                    begin
                        $error("capture_done: expected %0d, got %0d",
                               owed.capture_done, capture_done);
                        mismatch_count = mismatch_count + 1;
                    end
                end
                record_taken = 1'b1;
            end
            if (cfg_we)
                write_model_register(cfg_index, cfg_data);
            if (push && !full)
            begin
                log_wind_event('{kind, pin_level, vane_bits});
                item_taken = 1'b1;
            end
        end
    end

    // item driver, fed from the pending queue
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_taken)
            begin
                item_taken = 1'b0;
                holding    = 1'b0;
            end
            if (!holding)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    push <= 1'b0;
                end
                else if (events_to_send.size() != 0)
                begin
                    next_event = events_to_send.pop_front();
                    kind      <= next_event.kind;
                    pin_level <= next_event.pin_level;
                    vane_bits <= next_event.vane_bits;
                    push      <= 1'b1;
                    holding    = 1'b1;
                    send_gap   = pick_gap();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // record receiver with random stalls
    always @(negedge clk)
    begin
        if (record_taken)
        begin
            record_taken = 1'b0;
            pop_stall    = pick_gap();
        end
        if (pop_stall > 0)
        begin
            pop_stall = pop_stall - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    task automatic queue_event(input logic k, input logic lvl,
                               input logic [DIR_W-1:0] vane);
        wind_event_t ev;
        ev.kind      = k;
        ev.pin_level = lvl;
        ev.vane_bits = vane;
        events_to_send.push_back(ev);
    endtask

    // pulses with random vane bits, which the block ignores
    task automatic queue_pulses(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            queue_event(KIND_PIN, 1'b1, DIR_W'($urandom));
    endtask

    // sender holds off until every record has come, then the block settles
    task automatic drain_records();
        while (events_to_send.size() != 0 || holding || records_owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int unsigned      random_items;
        int unsigned      phase_len;
        int unsigned      n;
        int unsigned      pulses;
        int unsigned      r;
        int unsigned      fill;
        logic [CFG_W-1:0] data;

        random_items = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults: empty window, then a low pin and three pulses
        queue_event(KIND_TICK, 1'b0, 8'hFF);
        queue_event(KIND_PIN, 1'b0, 8'h3C);
        queue_pulses(3);
        queue_event(KIND_TICK, 1'b1, 8'h00);
        drain_records();

        // oversized window write clamps to the top, window left open
        write_register(REG_WINDOW_LEN, 11'h7FF);
        queue_pulses(1);
        queue_event(KIND_TICK, 1'b1, 8'h81);
        queue_pulses(2);
        queue_event(KIND_TICK, 1'b0, 8'h7E);
        drain_records();

        // window of four, then shortened after three ticks
        write_register(REG_WINDOW_LEN, 11'd4);
        queue_pulses(3);
        queue_event(KIND_TICK, 1'b0, 8'h11);
        drain_records();
        write_register(REG_WINDOW_LEN, 11'd2);
        queue_pulses(5);
        queue_event(KIND_TICK, 1'b1, 8'h55);
        drain_records();

        // zero capture length clamps to one, ticks are ignored, pulses count
        write_register(REG_ACTIVE_SAMPLES, 11'd0);
        queue_pulses(2);
        queue_event(KIND_TICK, 1'b1, 8'hC3);
        queue_pulses(1);
        queue_event(KIND_TICK, 1'b0, 8'h3C);
        drain_records();

        // capture resumes for two records, then stops again
        write_register(REG_WINDOW_LEN, 11'd0);
        write_register(REG_ACTIVE_SAMPLES, CFG_W'(record_count + 2));
        queue_event(KIND_TICK, 1'b0, 8'h01);
        queue_event(KIND_TICK, 1'b1, 8'h80);
        queue_pulses(1);
        queue_event(KIND_TICK, 1'b0, 8'hAA);
        drain_records();
        write_register(REG_ACTIVE_SAMPLES, 11'h7FF);
        queue_event(KIND_TICK, 1'b0, 8'hFE);
        drain_records();

        // random phases with varied settings
        while (random_items < RANDOM_ITEMS)
        begin
            drain_records();
            if ($urandom_range(0, 1))
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    data = CFG_W'($urandom_range(1, 3));
                else if (r < 8)
                    data = CFG_W'($urandom_range(4, 16));
                else if (r == 8)
                    data = CFG_W'($urandom_range(0, 2047));
                else
                    data = CFG_W'(MAX_AVG);
                write_register(REG_WINDOW_LEN, data);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    data = 11'h7FF;
                else if (r < 8)
                    data = CFG_W'(record_count + $urandom_range(1, 10));
                else
                    data = CFG_W'($urandom_range(0, 2047));
                write_register(REG_ACTIVE_SAMPLES, data);
            end
            phase_len = $urandom_range(20, 100);
            n = 0;
            while (n < phase_len)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // well-formed: a few pin changes, then a tick
                    pulses = $urandom_range(0, 5);
                    for (int unsigned i = 0; i < pulses; i++)
                        queue_event(KIND_PIN, ($urandom_range(0, 3) != 0),
                                    DIR_W'($urandom));
                    queue_event(KIND_TICK, 1'($urandom), DIR_W'($urandom));
                    n = n + pulses + 1;
                end
                else
                begin
                    queue_event(1'($urandom), 1'($urandom), DIR_W'($urandom));
                    n = n + 1;
                end
            end
            random_items = random_items + n;
        end
        drain_records();

        // close the capture a few records on, then a few ignored ticks
        write_register(REG_WINDOW_LEN, 11'd1);
        write_register(REG_ACTIVE_SAMPLES, CFG_W'(record_count + FINAL_RECORDS));
        fill = (record_count < active_samples) ? active_samples - record_count : 0;
        for (int unsigned i = 0; i < fill + 3; i++)
        begin
            if ($urandom_range(0, 1))
                queue_event(KIND_PIN, 1'($urandom), DIR_W'($urandom));
            queue_event(KIND_TICK, 1'($urandom), DIR_W'($urandom));
        end
        drain_records();

        if (mismatch_count == 0)
            $display("windowed_pulse_average_logger_core_tb OK");
        else
            $display("windowed_pulse_average_logger_core_tb NOT OK");
        $finish;
    end

endmodule
